>>> src/pbid_pkg.sv
`default_nettype none

package pbid_pkg;

    // Lookahead window depth and input queue depth
    localparam int unsigned WIN    = 7;
    localparam int unsigned QDEPTH = 4;

    // Command stream bytes
    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_IMAGE    = 8'h2A;
    localparam logic [7:0] BYTE_OFFSET   = 8'h24;
    localparam logic [7:0] BYTE_FEED     = 8'h4A;
    localparam logic [7:0] BYTE_PAD      = 8'h40;
    localparam logic [7:0] MODE_RESET    = 8'h28;
    localparam logic [7:0] MODE_NARROW_HI = 8'h06;
    localparam logic [7:0] MODE_WIDE_LO  = 8'h20;
    localparam logic [7:0] MODE_WIDE_HI  = 8'h28;

    // Result kinds
    localparam logic [1:0] KIND_DRAW = 2'd0;
    localparam logic [1:0] KIND_MARK = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Blank-page marker position
    localparam int unsigned MARK_POS = 10;

    // Offset scaling: pending * dpi / 3600 == pending / (3600 / dpi), done as
    // pending * ceil(2^22 / q) >> 22, exact for every 16-bit pending.
    localparam int unsigned SCALE_SHIFT = 22;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_qword;

    typedef struct packed {
        logic        ok;
        logic [18:0] recip;
    } t_scale;

    function automatic t_scale mode_scale(input logic [7:0] mode);
        t_scale s;
        s.ok = 1'b1;
        unique case (mode)
            8'h00:   s.recip = 19'd69906;   // 60 dpi
            8'h01:   s.recip = 19'd139811;  // 120 dpi
            8'h02:   s.recip = 19'd139811;  // 120 dpi
            8'h03:   s.recip = 19'd279621;  // 240 dpi
            8'h04:   s.recip = 19'd93207;   // 80 dpi
            8'h06:   s.recip = 19'd104858;  // 90 dpi
            8'h20:   s.recip = 19'd69906;   // 60 dpi
            8'h21:   s.recip = 19'd139811;  // 120 dpi
            8'h26:   s.recip = 19'd104858;  // 90 dpi
            8'h27:   s.recip = 19'd209716;  // 180 dpi
            8'h28:   s.recip = 19'd419431;  // 360 dpi
            default: begin
                s.ok    = 1'b0;
                s.recip = '0;
            end
        endcase
        return s;
    endfunction

    function automatic logic is_image_mode(input logic [7:0] mode);
        return (mode <= MODE_NARROW_HI) || (mode >= MODE_WIDE_LO && mode <= MODE_WIDE_HI);
    endfunction

endpackage

`default_nettype wire

>>> src/pbid_front.sv
`default_nettype none

module pbid_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  wire logic [7:0]      i_s_axis_tdata,   // data_byte
    input  wire logic            i_s_axis_tlast,   // last_byte
    output logic                 o_q_valid,
    output pbid_pkg::t_qword     o_q_word,
    input  wire logic            i_q_pop
);
    import pbid_pkg::*;

    localparam int unsigned PW = $clog2(QDEPTH);

    t_qword           r_mem [0:QDEPTH-1];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [PW:0]      r_cnt;
    logic             push;

    assign o_s_axis_tready = (r_cnt != (PW+1)'(QDEPTH));
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_q_valid       = (r_cnt != '0);
    assign o_q_word        = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= '{data: i_s_axis_tdata, last: i_s_axis_tlast};
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/pbid_back.sv
`default_nettype none

module pbid_back #(
    parameter int unsigned X_BITS     = 17,
    parameter int unsigned Y_BITS     = 16,
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    input  wire pbid_pkg::t_qword      i_q_word,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [1:0]                 o_kind,
    output logic [X_BITS-1:0]          o_x,
    output logic [Y_BITS-1:0]          o_y,
    output logic [7:0]                 o_bits,
    output logic [COUNT_BITS-1:0]      o_dots,
    output logic [COUNT_BITS-1:0]      o_cons,
    output logic                       o_last
);
    import pbid_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_MODE, PH_MODE_T, PH_NL, PH_NL_T, PH_NH, PH_NH_T,
        PH_RUN, PH_DLO, PH_DHI, PH_FEED
    } t_phase;

    localparam int unsigned XS = ((X_BITS > 16) ? X_BITS : 16) + 1;
    localparam logic [X_BITS-1:0]     X_MAX = '1;
    localparam logic [Y_BITS-1:0]     Y_MAX = '1;
    localparam logic [COUNT_BITS-1:0] C_MAX = '1;

    logic [7:0]            r_win [0:WIN-1];
    logic [2:0]            r_fill;
    t_phase                r_phase;
    logic [2:0]            r_skip;
    logic [7:0]            r_mode;
    logic [15:0]           r_cols;
    logic [1:0]            r_row_in;
    logic [X_BITS-1:0]     r_col;
    logic [Y_BITS-1:0]     r_row;
    logic [15:0]           r_pend;
    logic [COUNT_BITS-1:0] r_dots, r_seen;
    logic                  r_drain, r_endst;
    logic                  r_ov, r_last;
    logic [1:0]            r_kind;
    logic [X_BITS-1:0]     r_x;
    logic [Y_BITS-1:0]     r_y;
    logic [7:0]            r_bits;
    logic [COUNT_BITS-1:0] r_dcnt, r_cons;

    logic [7:0]            n_win [0:WIN-1];
    logic [2:0]            n_fill;
    t_phase                n_phase;
    logic [2:0]            n_skip;
    logic [7:0]            n_mode;
    logic [15:0]           n_cols;
    logic [1:0]            n_row_in;
    logic [X_BITS-1:0]     n_col;
    logic [Y_BITS-1:0]     n_row;
    logic [15:0]           n_pend;
    logic [COUNT_BITS-1:0] n_dots, n_seen;
    logic                  n_drain, n_endst;
    logic                  n_ov, n_last;
    logic [1:0]            n_kind;
    logic [X_BITS-1:0]     n_x;
    logic [Y_BITS-1:0]     n_y;
    logic [7:0]            n_bits;
    logic [COUNT_BITS-1:0] n_dcnt, n_cons;

    // Datapath around the window head
    logic                  adv, step, finish, consume, push;
    logic [7:0]            h;
    logic                  wide, narrow, hdr_hit, noise7, noise6, cut;
    t_scale                scale;
    logic [34:0]           pend_mul;
    logic [15:0]           h_mul;
    logic [7:0]            feed_amt;
    logic [Y_BITS:0]       feed_sum, y_sum;
    logic [X_BITS:0]       col_inc;
    logic [XS-1:0]         col_add;
    logic [COUNT_BITS:0]   dots_sum;
    logic [2:0]            fill_mid;

    assign adv    = !r_ov || i_ready;
    assign step   = adv && (r_fill != 3'd0) && ((r_fill == 3'(WIN)) || r_drain);
    assign finish = adv && r_drain && (r_fill == 3'd0);
    assign h      = r_win[0];
    assign wide   = (r_mode >= MODE_WIDE_LO);
    assign narrow = (r_mode <= MODE_NARROW_HI);

    assign hdr_hit = (r_fill > 3'd1) && (r_win[0] == BYTE_PAD) && (r_win[1] == BYTE_PAD);
    assign noise7  = (r_fill == 3'(WIN)) && (r_win[0] == 8'h00) && (r_win[1] == 8'h00)
                  && (r_win[2] == 8'h00) && (r_win[3] == 8'h0D) && (r_win[4] == 8'h01)
                  && (r_win[5] == 8'h00) && (r_win[6] == 8'h04);
    assign noise6  = (r_fill >= 3'd6) && (r_win[0] == BYTE_PAD) && (r_win[1] == BYTE_PAD)
                  && (((r_win[2] == 8'h10) && (r_win[3] == 8'h06)
                       && (r_win[4] == 8'h00) && (r_win[5] == 8'h00))
                   || ((r_win[4] == 8'h00) && (r_win[5] == 8'h01))
                   || ((r_win[2] == 8'h00) && (r_win[3] == 8'h80)
                       && (r_win[4] == 8'hFF) && (r_win[5] == 8'hFF)));
    assign cut     = (h == BYTE_ESC) && (r_fill > 3'd1)
                  && ((r_win[1] == BYTE_FEED) || (r_win[1] == BYTE_IMAGE));

    assign scale    = mode_scale(r_mode);
    assign pend_mul = 35'(r_pend) * 35'(scale.recip);
    assign h_mul    = 16'(h) * 16'd171;   // h / 3 for any byte
    assign feed_amt = narrow ? {1'b0, h_mul[15:9]} : h;
    assign feed_sum = {1'b0, r_row} + (Y_BITS+1)'(feed_amt);
    assign y_sum    = {1'b0, r_row} + (Y_BITS+1)'(wide ? {r_row_in, 3'b000} : 5'd0);
    assign col_inc  = {1'b0, r_col} + (X_BITS+1)'(1);
    assign col_add  = XS'(r_col) + XS'(r_cols);
    assign dots_sum = {1'b0, r_dots} + (COUNT_BITS+1)'(8);

    always_comb begin
        n_fill   = r_fill;
        n_phase  = r_phase;
        n_skip   = r_skip;
        n_mode   = r_mode;
        n_cols   = r_cols;
        n_row_in = r_row_in;
        n_col    = r_col;
        n_row    = r_row;
        n_pend   = r_pend;
        n_dots   = r_dots;
        n_seen   = r_seen;
        n_drain  = r_drain;
        n_endst  = r_endst;
        n_ov     = adv ? 1'b0 : r_ov;
        n_kind   = r_kind;
        n_x      = r_x;
        n_y      = r_y;
        n_bits   = r_bits;
        n_dcnt   = r_dcnt;
        n_cons   = r_cons;
        n_last   = r_last;
        consume  = 1'b0;

        if (step) begin
            if (r_skip != 3'd0) begin
                n_skip  = r_skip - 1'b1;
                consume = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_MODE, PH_MODE_T: begin
                        consume = 1'b1;
                        if (r_phase == PH_MODE && hdr_hit) begin
                            n_phase = PH_MODE_T;
                            n_skip  = 3'd5;
                        end else begin
                            n_mode  = h;
                            n_phase = PH_NL;
                        end
                    end
                    PH_NL, PH_NL_T: begin
                        consume = 1'b1;
                        if (r_phase == PH_NL && hdr_hit) begin
                            n_phase = PH_NL_T;
                            n_skip  = 3'd5;
                        end else begin
                            n_cols  = {8'h00, h};
                            n_phase = PH_NH;
                        end
                    end
                    PH_NH, PH_NH_T: begin
                        consume = 1'b1;
                        if (r_phase == PH_NH && hdr_hit) begin
                            n_phase = PH_NH_T;
                            n_skip  = 3'd5;
                        end else begin
                            // Header complete: place the image and start the run if the mode is an image mode
                            n_cols   = {h, r_cols[7:0]};
                            if (scale.ok) begin
                                n_col = X_BITS'(pend_mul[34:SCALE_SHIFT]);
                            end
                            n_pend   = '0;
                            n_row_in = '0;
                            n_phase  = is_image_mode(r_mode) ? PH_RUN : PH_IDLE;
                        end
                    end
                    PH_RUN: begin
                        priority if (r_cols == 16'd0) begin
                            n_phase = PH_IDLE;
                        end else if (noise7 || noise6) begin
                            n_skip  = noise7 ? 3'd6 : 3'd5;
                            consume = 1'b1;
                        end else if (cut) begin
                            if (wide) begin
                                n_col = (col_add > XS'(X_MAX)) ? X_MAX : col_add[X_BITS-1:0];
                            end
                            n_cols  = '0;
                            n_phase = PH_IDLE;
                        end else begin
                            n_ov     = 1'b1;
                            n_kind   = KIND_DRAW;
                            n_x      = r_col;
                            n_y      = y_sum[Y_BITS] ? Y_MAX : y_sum[Y_BITS-1:0];
                            n_bits   = h;
                            n_dcnt   = '0;
                            n_cons   = '0;
                            n_last   = !r_drain;
                            n_dots   = dots_sum[COUNT_BITS] ? C_MAX : dots_sum[COUNT_BITS-1:0];
                            consume  = 1'b1;
                            if (wide && r_row_in != 2'd2) begin
                                n_row_in = r_row_in + 1'b1;
                            end else begin
                                n_row_in = '0;
                                n_col    = col_inc[X_BITS] ? X_MAX : col_inc[X_BITS-1:0];
                                n_cols   = r_cols - 1'b1;
                            end
                        end
                    end
                    PH_DLO: begin
                        n_pend  = {8'h00, h};
                        n_phase = PH_DHI;
                        consume = 1'b1;
                    end
                    PH_DHI: begin
                        n_pend  = {h, r_pend[7:0]};
                        n_phase = PH_IDLE;
                        consume = 1'b1;
                    end
                    PH_FEED: begin
                        if (scale.ok) begin
                            n_row = feed_sum[Y_BITS] ? Y_MAX : feed_sum[Y_BITS-1:0];
                        end
                        n_phase = PH_IDLE;
                        consume = 1'b1;
                    end
                    default: begin
                        consume = 1'b1;
                        n_phase = PH_IDLE;
                        if (h == BYTE_ESC && r_fill > 3'd1) begin
                            priority if (r_win[1] == BYTE_IMAGE) begin
                                n_phase = PH_MODE;
                                n_skip  = 3'd1;
                            end else if (r_win[1] == BYTE_OFFSET) begin
                                n_phase = PH_DLO;
                                n_skip  = 3'd1;
                            end else if (r_win[1] == BYTE_FEED) begin
                                n_phase = PH_FEED;
                                n_skip  = 3'd1;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                endcase
            end
        end else if (finish) begin
            n_ov   = 1'b1;
            n_bits = '0;
            if (!r_endst && r_dots == '0) begin
                n_kind  = KIND_MARK;
                n_x     = X_BITS'(MARK_POS);
                n_y     = Y_BITS'(MARK_POS);
                n_dcnt  = '0;
                n_cons  = '0;
                n_last  = 1'b0;
                n_endst = 1'b1;
            end else begin
                n_kind   = KIND_END;
                n_x      = '0;
                n_y      = '0;
                n_dcnt   = r_dots;
                n_cons   = r_seen;
                n_last   = 1'b1;
                // Stream done: return to reset state
                n_endst  = 1'b0;
                n_drain  = 1'b0;
                n_phase  = PH_IDLE;
                n_skip   = '0;
                n_mode   = MODE_RESET;
                n_cols   = '0;
                n_row_in = '0;
                n_col    = '0;
                n_row    = '0;
                n_pend   = '0;
                n_dots   = '0;
                n_seen   = '0;
            end
        end

        // Window shift and refill
        fill_mid = consume ? (r_fill - 1'b1) : r_fill;
        push     = i_q_valid && !r_drain && ((r_fill != 3'(WIN)) || consume);
        for (int i = 0; i < WIN; i++) begin
            if (consume) begin
                n_win[i] = (i < WIN - 1) ? r_win[(i + 1) % WIN] : 8'h00;
            end else begin
                n_win[i] = r_win[i];
            end
        end
        n_fill = fill_mid;
        if (push) begin
            n_win[fill_mid] = i_q_word.data;
            n_fill          = fill_mid + 1'b1;
            n_seen          = (r_seen == C_MAX) ? C_MAX : r_seen + 1'b1;
            n_drain         = i_q_word.last;
        end
    end

    assign o_q_pop = push;
    assign o_valid = r_ov;
    assign o_kind  = r_kind;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_bits  = r_bits;
    assign o_dots  = r_dcnt;
    assign o_cons  = r_cons;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        r_win  <= n_win;
        r_kind <= n_kind;
        r_x    <= n_x;
        r_y    <= n_y;
        r_bits <= n_bits;
        r_dcnt <= n_dcnt;
        r_cons <= n_cons;
        r_last <= n_last;
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_phase  <= PH_IDLE;
            r_skip   <= '0;
            r_mode   <= MODE_RESET;
            r_cols   <= '0;
            r_row_in <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_pend   <= '0;
            r_dots   <= '0;
            r_seen   <= '0;
            r_drain  <= 1'b0;
            r_endst  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_mode   <= n_mode;
            r_cols   <= n_cols;
            r_row_in <= n_row_in;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pend   <= n_pend;
            r_dots   <= n_dots;
            r_seen   <= n_seen;
            r_drain  <= n_drain;
            r_endst  <= n_endst;
            r_ov     <= n_ov;
        end
    end

endmodule

`default_nettype wire

>>> src/printer_bit_image_decoder_unit.sv
// A word taken from the link is written to the queue, then pushed into the lookahead window;
//   the draw it causes is registered at the output once the 7-byte window is full (a byte
//   is decided when six more follow).
// Throughput: one word per cycle while the output is not stalled; a run cut short or an
//   empty run costs an extra parser step; stream end drains the window before the end results.
// Reset: i_rst_n synchronous, active low; clears queue, window and parser state.
`default_nettype none

module printer_bit_image_decoder_unit #(
    parameter int unsigned X_BITS     = 17,
    parameter int unsigned Y_BITS     = 16,
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [7:0]    i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic          i_s_axis_tlast,   // last_byte
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // x_coord, y_coord, column_bits, dot_count, consumed_bytes, zero fill
    output logic [(((X_BITS + Y_BITS + 8 + 2 * COUNT_BITS) + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    output logic [1:0]         o_m_axis_tuser,   // [1:0] kind
    output logic               o_m_axis_tlast    // last
);
    import pbid_pkg::*;

    localparam int unsigned RAW_W = X_BITS + Y_BITS + 8 + 2 * COUNT_BITS;
    localparam int unsigned TD_W  = ((RAW_W + 7) / 8) * 8;

    logic                  q_valid, q_pop;
    t_qword                q_word;
    logic [X_BITS-1:0]     x;
    logic [Y_BITS-1:0]     y;
    logic [7:0]            bits;
    logic [COUNT_BITS-1:0] dots, cons;

    // Front: take words from the link into a short queue
    pbid_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_q_valid       (q_valid),
        .o_q_word        (q_word),
        .i_q_pop         (q_pop)
    );

    // Back: lookahead window, command parser and output register
    pbid_back #(
        .X_BITS     (X_BITS),
        .Y_BITS     (Y_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_word  (q_word),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_kind    (o_m_axis_tuser),
        .o_x       (x),
        .o_y       (y),
        .o_bits    (bits),
        .o_dots    (dots),
        .o_cons    (cons),
        .o_last    (o_m_axis_tlast)
    );

    // Pack fields lowest first, zero fill to whole bytes
    assign o_m_axis_tdata = TD_W'({cons, dots, bits, y, x});

endmodule

`default_nettype wire
